// ----- src/vrc_pkg.sv -----
// ----------------------------------------------------------------------------
// vrc_pkg
// Shared types, constants and helpers of the vertical resampling filter.
// ----------------------------------------------------------------------------
`default_nettype none

package vrc_pkg;

  localparam int MaxColumns = 4096;
  localparam int ColW       = $clog2(MaxColumns);
  localparam int NumChan    = 4;
  localparam int PixW       = 8;
  localparam int WeightW    = 16;
  localparam int AccW       = 32;
  localparam int PrecW      = 5;
  localparam int ProdW      = PixW + 1 + WeightW;
  localparam int QueueDepth = 4;
  localparam int QueueAw    = $clog2(QueueDepth);
  localparam int PendW      = $clog2(QueueDepth + 1);

  localparam logic [PrecW-1:0] PrecReset = PrecW'(22);
  localparam logic [AccW-1:0]  ChanMax   = AccW'(255);

  typedef logic [AccW-1:0] acc_t;
  typedef logic [NumChan-1:0][AccW-1:0] sums_t;
  typedef logic [NumChan-1:0][PixW-1:0] pix_t;

  // one source pixel on its way into the accumulators
  typedef struct packed {
    logic [ColW-1:0]           column;
    pix_t                      pix;
    logic signed [WeightW-1:0] weight;
    logic                      first_tap;
    logic                      last_tap;
  } tap_t;

  // finished column sums
  typedef struct packed {
    logic [ColW-1:0] column;
    sums_t           sums;
  } done_t;

  // output pixel waiting in the queue
  typedef struct packed {
    logic [ColW-1:0] column;
    pix_t            chans;
  } result_t;

  function automatic acc_t round_bias(input logic [PrecW-1:0] prec);
    acc_t one;
    one = acc_t'(1);
    if (prec == '0) begin
      return '0;
    end
    return one << (prec - PrecW'(1));
  endfunction

  function automatic logic [PixW-1:0] shift_clamp(input acc_t sum,
                                                  input logic [PrecW-1:0] prec);
    acc_t shifted;
    shifted = acc_t'($signed(sum) >>> prec);
    if (shifted[AccW-1]) begin
      return '0;
    end
    if (shifted > ChanMax) begin
      return ChanMax[PixW-1:0];
    end
    return shifted[PixW-1:0];
  endfunction

endpackage

`default_nettype wire

// ----- src/vrc_ram.sv -----
// ----------------------------------------------------------------------------
// vrc_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module vrc_ram #(
  parameter int Width = 32,
  parameter int Depth = 256
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(Depth)-1:0] wr_addr,
  input  wire logic [Width-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(Depth)-1:0] rd_addr,
  output logic      [Width-1:0]         rd_data
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ----- src/vrc_accum.sv -----
// ----------------------------------------------------------------------------
// vrc_accum
// Column accumulator read-modify-write around the sum memory.
// ----------------------------------------------------------------------------
`default_nettype none

module vrc_accum (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   tap_valid,
  input  wire vrc_pkg::tap_t          tap,
  input  wire logic [vrc_pkg::PrecW-1:0] prec,
  output logic                        done_valid,
  output vrc_pkg::done_t              done
);
  import vrc_pkg::*;

  logic  s1_valid;
  tap_t  s1;
  sums_t rd_data;
  sums_t sums;
  sums_t base;
  acc_t  bias;
  logic  fwd_valid;
  logic  [ColW-1:0] fwd_column;
  sums_t fwd_sums;
  logic  fwd_hit;
  logic  signed [ProdW-1:0] prod [NumChan];

  vrc_ram #(
    .Width(NumChan * AccW),
    .Depth(MaxColumns)
  ) u_sum_ram (
    .clk    (clk),
    .wr_en  (s1_valid),
    .wr_addr(s1.column),
    .wr_data(sums),
    .rd_en  (tap_valid),
    .rd_addr(tap.column),
    .rd_data(rd_data)
  );

  assign bias    = round_bias(prec);
  // the ram returns old data for the entry written in the same cycle
  assign fwd_hit = fwd_valid && (fwd_column == s1.column);

  always_comb begin
    for (int c = 0; c < NumChan; c++) begin
      prod[c] = $signed({1'b0, s1.pix[c]}) * s1.weight;
      if (s1.first_tap) begin
        base[c] = bias;
      end else if (fwd_hit) begin
        base[c] = fwd_sums[c];
      end else begin
        base[c] = rd_data[c];
      end
      sums[c] = base[c] + {{(AccW - ProdW){prod[c][ProdW-1]}}, prod[c]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid   <= 1'b0;
      fwd_valid  <= 1'b0;
      done_valid <= 1'b0;
    end else begin
      s1_valid   <= tap_valid;
      fwd_valid  <= s1_valid;
      done_valid <= s1_valid && s1.last_tap;
    end
    s1          <= tap;
    fwd_column  <= s1.column;
    fwd_sums    <= sums;
    done.column <= s1.column;
    done.sums   <= sums;
  end

endmodule

`default_nettype wire

// ----- src/vrc_result_queue.sv -----
// ----------------------------------------------------------------------------
// vrc_result_queue
// Final shift and clamp of finished sums, then a small output queue.
// ----------------------------------------------------------------------------
`default_nettype none

module vrc_result_queue (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      done_valid,
  input  wire vrc_pkg::done_t            done,
  input  wire logic [vrc_pkg::PrecW-1:0] prec,
  output logic                           res_valid,
  input  wire logic                      res_ready,
  output vrc_pkg::result_t               res
);
  import vrc_pkg::*;

  result_t              entries [QueueDepth];
  result_t              wr_item;
  logic [QueueAw-1:0]   wr_ptr;
  logic [QueueAw-1:0]   rd_ptr;
  logic [PendW-1:0]     count;
  logic                 pop;

  always_comb begin
    wr_item.column = done.column;
    for (int c = 0; c < NumChan; c++) begin
      wr_item.chans[c] = shift_clamp(done.sums[c], prec);
    end
  end

  assign res_valid = (count != '0);
  assign res       = entries[rd_ptr];
  assign pop       = res_valid && res_ready;

  // no full check: upstream credits keep the queue from overflowing
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (done_valid) begin
        wr_ptr <= wr_ptr + QueueAw'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QueueAw'(1);
      end
      count <= count + PendW'(done_valid) - PendW'(pop);
    end
    if (done_valid) begin
      entries[wr_ptr] <= wr_item;
    end
  end

endmodule

`default_nettype wire

// ----- src/vertical_resample_convolution_unit.sv -----
// ----------------------------------------------------------------------------
// vertical_resample_convolution_unit
// Vertical pass of a separable resampler for four 8-bit channel pixels.
// ----------------------------------------------------------------------------
// Usage:
//   Source pixels enter on in_valid/in_ready, row by row, one per cycle, each
//   with its column, its row coefficient and first/last tap flags. Per column
//   four 32-bit sums live in a 4096 x 128 bit memory; every item does one
//   read-modify-write of its column entry, with the last written entry
//   forwarded so that back-to-back items on one column see each other.
//   A last tap emits one output pixel on out_valid/out_ready.
//   Throughput: one item per cycle while in_ready is high, limited by the
//   single read and write port of the sum memory. A pixel passes the s1
//   (memory read) and done registers, then shift and clamp into a four-entry
//   queue; a credit count over results in flight drops in_ready only when the
//   queue could overflow, so a stalled receiver holds the input after at most
//   four pending results. coef_precision must be written by the user through
//   cfg_wr_en/cfg_wr_data only while idle; the block does not enforce this.
//   Reset sets coef_precision to 22 and empties the pipeline and queue; the
//   sum memory is not cleared, each column must start with a first tap.
// ----------------------------------------------------------------------------
`default_nettype none

module vertical_resample_convolution_unit (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_wr_en,
  input  wire logic [vrc_pkg::PrecW-1:0]     cfg_wr_data,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [vrc_pkg::ColW-1:0]      column,
  input  wire logic [vrc_pkg::PixW-1:0]      chan0,
  input  wire logic [vrc_pkg::PixW-1:0]      chan1,
  input  wire logic [vrc_pkg::PixW-1:0]      chan2,
  input  wire logic [vrc_pkg::PixW-1:0]      chan3,
  input  wire logic signed [vrc_pkg::WeightW-1:0] weight,
  input  wire logic                          first_tap,
  input  wire logic                          last_tap,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [vrc_pkg::ColW-1:0]           out_column,
  output logic [vrc_pkg::PixW-1:0]           out0,
  output logic [vrc_pkg::PixW-1:0]           out1,
  output logic [vrc_pkg::PixW-1:0]           out2,
  output logic [vrc_pkg::PixW-1:0]           out3
);
  import vrc_pkg::*;

  logic [PrecW-1:0] coef_precision;
  logic [PendW-1:0] pending;
  logic             in_fire;
  logic             out_fire;
  tap_t             tap;
  logic             done_valid;
  done_t            done;
  result_t          res;

  assign in_ready = (pending < PendW'(QueueDepth));
  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid && out_ready;

  assign tap.column    = column;
  assign tap.pix       = {chan3, chan2, chan1, chan0};
  assign tap.weight    = weight;
  assign tap.first_tap = first_tap;
  assign tap.last_tap  = last_tap;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef_precision <= PrecReset;
      pending        <= '0;
    end else begin
      if (cfg_wr_en) begin
        coef_precision <= cfg_wr_data;
      end
      // results in flight plus queued
      pending <= pending + PendW'(in_fire && last_tap) - PendW'(out_fire);
    end
  end

  vrc_accum u_accum (
    .clk       (clk),
    .rst       (rst),
    .tap_valid (in_fire),
    .tap       (tap),
    .prec      (coef_precision),
    .done_valid(done_valid),
    .done      (done)
  );

  vrc_result_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .done_valid(done_valid),
    .done      (done),
    .prec      (coef_precision),
    .res_valid (out_valid),
    .res_ready (out_ready),
    .res       (res)
  );

  assign out_column = res.column;
  assign out0       = res.chans[0];
  assign out1       = res.chans[1];
  assign out2       = res.chans[2];
  assign out3       = res.chans[3];

endmodule

`default_nettype wire

// ----- tb/sv/vertical_resample_convolution_unit_test.sv -----
// ----------------------------------------------------------------------------
// vertical_resample_convolution_unit_test
// Self-checking bench for the vertical resampling filter. Source pixels are
// sent as short multi-tap frames, broken frames and loose taps, under several
// coefficient precisions. Every output pixel is compared with a local
// column-sum predictor.
// ----------------------------------------------------------------------------
`default_nettype none

module vertical_resample_convolution_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import vrc_pkg::*;

  // per-column sums and the queue of output pixels they will produce
  class column_sum_scoreboard;
    logic [PrecW-1:0] precision;
    logic [NumChan-1:0][AccW-1:0] col_sums [MaxColumns];
    bit col_written [MaxColumns];
    result_t pixels_due [$];
    int taps_seen;
    int pixels_checked;
    int errors;

    function new();
      precision = PrecReset;
    endfunction

    function void note_tap(logic [ColW-1:0] col, pix_t pix, logic signed [WeightW-1:0] w,
                           logic first, logic last);
      logic [AccW-1:0] bias;
      logic [AccW-1:0] prod;
      logic [AccW-1:0] sum;
      logic signed [AccW-1:0] scaled;
      result_t px;
      bias = (precision == '0) ? '0 : (AccW'(1) << (precision - 1));
      px.column = col;
      for (int ch = 0; ch < NumChan; ch++) begin
        prod = {24'd0, pix[ch]} * {{16{w[WeightW-1]}}, w};
        sum = (first ? bias : col_sums[col][ch]) + prod;
        col_sums[col][ch] = sum;
        scaled = $signed(sum) >>> precision;
        if (scaled < 0) begin
          px.chans[ch] = 8'd0;
        end else if (scaled > 255) begin
          px.chans[ch] = 8'd255;
        end else begin
          px.chans[ch] = scaled[PixW-1:0];
        end
      end
      col_written[col] = 1'b1;
      taps_seen++;
      if (last) begin
        pixels_due.push_back(px);
      end
    endfunction

    function void check_pixel(logic [ColW-1:0] col, pix_t chans);
      result_t want;
      if (pixels_due.size() == 0) begin
        errors++;
        if (errors <= 10) begin
          $display("unexpected output pixel: column %0d chans %h", col, chans);
        end
        return;
      end
      want = pixels_due.pop_front();
      pixels_checked++;
      if (want.column !== col || want.chans !== chans) begin
        errors++;
        if (errors <= 10) begin
          $display("pixel mismatch: expected column %0d chans %h, got column %0d chans %h",
                   want.column, want.chans, col, chans);
        end
      end
    endfunction

    function void close_out();
      if (pixels_due.size() != 0) begin
        $display("%0d output pixels never arrived", pixels_due.size());
        errors += pixels_due.size();
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_wr_en = 1'b0;
  logic [PrecW-1:0] cfg_wr_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [ColW-1:0] column = '0;
  logic [PixW-1:0] chan0 = '0;
  logic [PixW-1:0] chan1 = '0;
  logic [PixW-1:0] chan2 = '0;
  logic [PixW-1:0] chan3 = '0;
  logic signed [WeightW-1:0] weight = '0;
  logic first_tap = 1'b0;
  logic last_tap = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [ColW-1:0] out_column;
  logic [PixW-1:0] out0;
  logic [PixW-1:0] out1;
  logic [PixW-1:0] out2;
  logic [PixW-1:0] out3;

  column_sum_scoreboard sb = new();

  bit steady = 1'b0;
  int stall_requests = 0;
  int stalls_served = 0;
  int hold_left = 0;
  int items_sent = 0;
  int frames_sent = 0;
  int precision_writes = 0;
  int last_base = 0;

  vertical_resample_convolution_unit u_top (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .column     (column),
    .chan0      (chan0),
    .chan1      (chan1),
    .chan2      (chan2),
    .chan3      (chan3),
    .weight     (weight),
    .first_tap  (first_tap),
    .last_tap   (last_tap),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_column (out_column),
    .out0       (out0),
    .out1       (out1),
    .out2       (out2),
    .out3       (out3)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // receiver: check on handshake, then choose next ready
  initial begin
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) begin
        sb.check_pixel(out_column, {out3, out2, out1, out0});
      end
      if (stall_requests != stalls_served) begin
        stalls_served++;
        hold_left = 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= steady ? 1'b1 : ($urandom_range(0, 99) >= 18);
      end
    end
  end

  // idle gaps before some items when not steady
  task automatic send_tap(logic [ColW-1:0] col, pix_t pix, logic signed [WeightW-1:0] w,
                          logic first, logic last);
    if (!steady && $urandom_range(0, 99) < 9) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    column <= col;
    chan0 <= pix[0];
    chan1 <= pix[1];
    chan2 <= pix[2];
    chan3 <= pix[3];
    weight <= w;
    first_tap <= first;
    last_tap <= last;
    do @(posedge clk); while (!in_ready);
    sb.note_tap(col, pix, w, first, last);
    items_sent++;
  endtask

  task automatic wait_drained();
    while (sb.pixels_due.size() != 0) @(posedge clk);
  endtask

  task automatic write_precision(logic [PrecW-1:0] p);
    in_valid <= 1'b0;
    wait_drained();
    // taps without a last flag may still be in the pipeline
    repeat (8) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= p;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.precision = p;
    precision_writes++;
  endtask

  function automatic pix_t pick_pixel();
    pix_t p;
    for (int ch = 0; ch < NumChan; ch++) begin
      case ($urandom_range(0, 9))
        0: p[ch] = 8'd0;
        1: p[ch] = 8'd255;
        default: p[ch] = 8'($urandom);
      endcase
    end
    return p;
  endfunction

  // normalized weights keep sums in the interesting range, raw ones saturate
  function automatic logic signed [WeightW-1:0] pick_weight(int taps, bit norm);
    int unit;
    int v;
    if (!norm) begin
      return WeightW'($urandom_range(0, 65535));
    end
    unit = (sb.precision >= 15) ? 32767 : (1 << sb.precision);
    v = unit / taps + int'($urandom_range(0, unit / 2)) - unit / 4;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return WeightW'(v);
  endfunction

  task automatic send_frame(int base, int width, int taps, bit truncate, bit norm);
    logic signed [WeightW-1:0] w;
    for (int r = 0; r < taps; r++) begin
      w = pick_weight(taps, norm);
      for (int c = 0; c < width; c++) begin
        send_tap(ColW'(base + c), pick_pixel(), w, r == 0, (r == taps - 1) && !truncate);
      end
    end
    last_base = base;
    frames_sent++;
  endtask

  task automatic send_loose_taps(int count);
    logic [ColW-1:0] col;
    logic first;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 1)) begin
        col = ColW'(last_base + $urandom_range(0, 7));
      end else begin
        col = ColW'($urandom_range(0, MaxColumns - 1));
      end
      // never continue a column that has no sums yet
      first = !sb.col_written[col] || ($urandom_range(0, 3) == 0);
      send_tap(col, pick_pixel(), WeightW'($urandom_range(0, 65535)), first,
               $urandom_range(0, 1));
    end
  endtask

  // receiver holds off while single-tap pixels keep coming
  task automatic fill_while_stalled();
    stall_requests++;
    for (int i = 0; i < 24; i++) begin
      send_tap(ColW'($urandom_range(0, MaxColumns - 1)), pick_pixel(),
               WeightW'($urandom_range(0, 65535)), 1'b1, 1'b1);
    end
  endtask

  initial begin
    #2_000_000;
    $display("[vertical_resample_convolution_unit] ERROR");
    $finish;
  end

  initial begin
    int pick;
    int next_config;
    int stalls_done;
    int wait_cycles;
    logic [PrecW-1:0] p;

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset precision, field extremes
    send_tap(12'd0, {8'd255, 8'd255, 8'd255, 8'd255}, 16'sh7fff, 1'b1, 1'b1);
    send_tap(12'd4095, {8'd0, 8'd0, 8'd0, 8'd0}, -16'sh8000, 1'b1, 1'b1);
    send_tap(12'd4095, {8'd255, 8'd1, 8'd128, 8'd255}, -16'sh8000, 1'b1, 1'b1);
    // three taps on one column in succession
    send_tap(12'd7, {8'd10, 8'd20, 8'd30, 8'd40}, 16'sh4000, 1'b1, 1'b0);
    send_tap(12'd7, {8'd250, 8'd0, 8'd255, 8'd3}, 16'sh7fff, 1'b0, 1'b0);
    send_tap(12'd7, {8'd255, 8'd255, 8'd0, 8'd9}, -16'sh1234, 1'b0, 1'b1);
    // open column, another column, then close the first
    send_tap(12'd100, {8'd255, 8'd255, 8'd255, 8'd255}, 16'sh7fff, 1'b1, 1'b0);
    send_tap(12'd101, {8'd1, 8'd2, 8'd3, 8'd4}, 16'sh0100, 1'b1, 1'b1);
    send_tap(12'd100, {8'd255, 8'd255, 8'd255, 8'd255}, 16'sh7fff, 1'b0, 1'b1);

    // precision zero: no bias, no shift
    write_precision(5'd0);
    send_tap(12'd1, {8'd200, 8'd0, 8'd255, 8'd17}, 16'sh0001, 1'b1, 1'b1);
    send_tap(12'd2, {8'd255, 8'd127, 8'd128, 8'd1}, 16'sh0002, 1'b1, 1'b1);
    send_tap(12'd3, {8'd5, 8'd255, 8'd0, 8'd90}, -16'sh0001, 1'b1, 1'b1);
    send_tap(12'd1, {8'd40, 8'd1, 8'd1, 8'd1}, 16'sh0001, 1'b0, 1'b1);

    // widest shift
    write_precision(5'd31);
    send_tap(12'd2048, {8'd255, 8'd255, 8'd255, 8'd255}, 16'sh7fff, 1'b1, 1'b0);
    send_tap(12'd2048, {8'd255, 8'd255, 8'd255, 8'd255}, -16'sh8000, 1'b0, 1'b1);

    write_precision(5'd1);
    send_tap(12'd5, {8'd255, 8'd1, 8'd0, 8'd2}, 16'sh0001, 1'b1, 1'b1);
    send_tap(12'd6, {8'd255, 8'd255, 8'd3, 8'd0}, 16'sh7fff, 1'b1, 1'b1);

    write_precision(5'd30);
    send_tap(12'd4000, {8'd255, 8'd200, 8'd100, 8'd0}, 16'sh7fff, 1'b1, 1'b0);
    send_tap(12'd4000, {8'd255, 8'd200, 8'd100, 8'd0}, 16'sh7fff, 1'b0, 1'b1);

    next_config = items_sent + 200;
    stalls_done = 0;
    while (items_sent < 1320) begin
      if (items_sent >= next_config) begin
        case ($urandom_range(0, 4))
          0: p = 5'd0;
          1: p = 5'd31;
          default: p = 5'($urandom_range(1, 30));
        endcase
        write_precision(p);
        next_config = items_sent + 250;
      end
      steady = (items_sent >= 500 && items_sent < 800);
      if ((stalls_done == 0 && items_sent >= 300) || (stalls_done == 1 && items_sent >= 1000)) begin
        fill_while_stalled();
        stalls_done++;
      end
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        if ($urandom_range(0, 9) == 0) begin
          send_frame($urandom_range(0, MaxColumns - 1), $urandom_range(9, 32), 2, 1'b0,
                     $urandom_range(0, 1));
        end else begin
          send_frame($urandom_range(0, MaxColumns - 1), $urandom_range(1, 8),
                     $urandom_range(1, 6), 1'b0, $urandom_range(0, 2) != 0);
        end
      end else if (pick < 85) begin
        send_loose_taps($urandom_range(1, 5));
      end else begin
        send_frame($urandom_range(0, MaxColumns - 1), $urandom_range(1, 6),
                   $urandom_range(1, 4), 1'b1, $urandom_range(0, 1));
      end
    end
    steady = 1'b0;
    in_valid <= 1'b0;

    wait_cycles = 0;
    while (sb.pixels_due.size() != 0 && wait_cycles < 5000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (10) @(posedge clk);
    sb.close_out();

    $display("sent %0d taps in %0d frames plus loose taps, %0d precision writes",
             sb.taps_seen, frames_sent, precision_writes);
    $display("checked %0d output pixels, %0d receiver hold-offs, %0d failures",
             sb.pixels_checked, stalls_served, sb.errors);
    if (sb.errors == 0) begin
      $display("[vertical_resample_convolution_unit] OK");
    end else begin
      $display("[vertical_resample_convolution_unit] ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
